### rtl/core/lpfrs_pkg.sv
// Shared types and constants for the LED panel frame receiver and scanner.
// No dependencies; lpfrs_rx, lpfrs_scan and the top level import this package.
`timescale 1ns / 1ps

package lpfrs_pkg;

    // Panel geometry
    localparam int BOARDS          = 6;
    localparam int BYTES_PER_BOARD = 64;
    localparam int HOLD_TICKS      = 8;

    localparam int BOARD_W    = 3;
    localparam int OFFSET_W   = 6;
    localparam int ADDR_W     = BOARD_W + OFFSET_W;
    localparam int STORE_SIZE = BOARDS * BYTES_PER_BOARD;
    localparam int FILL_W     = $clog2(STORE_SIZE + 1);
    localparam int HOLD_W     = (HOLD_TICKS > 1) ? $clog2(HOLD_TICKS) : 1;

    // Serial framing symbols
    localparam logic [7:0] SYM_SOH   = 8'h01;
    localparam logic [7:0] SYM_EOT   = 8'h04;
    localparam logic [7:0] SYM_ESC   = 8'h1b;
    localparam logic [7:0] SYM_X_SOH = 8'h78;
    localparam logic [7:0] SYM_X_EOT = 8'h79;
    localparam logic [7:0] SYM_X_ESC = 8'h7a;

    // Input operation codes
    localparam logic OP_RX_BYTE   = 1'b0;
    localparam logic OP_SCAN_TICK = 1'b1;

    // Framebuffer write request from the receiver
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_req_t;

    // Per-tick scan control from the scanner
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              pix;
        logic [2:0]        bit_idx;
        logic              data;
        logic              clk;
        logic              mode;
        logic              strobe;
    } scan_ctl_t;

endpackage

### rtl/core/lpfrs_in_if.sv
// Input channel: valid/ready handshake carrying one operation word.
// Depends on nothing.
`timescale 1ns / 1ps

interface lpfrs_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

### rtl/core/lpfrs_out_if.sv
// Output channel: valid/ready handshake carrying one scan result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface lpfrs_out_if;
    logic valid;
    logic ready;
    logic shift_data;
    logic shift_clock;
    logic mode_select;
    logic strobe_res;

    modport source (output valid, output shift_data, output shift_clock,
                    output mode_select, output strobe_res, input ready);
    modport sink   (input valid, input shift_data, input shift_clock,
                    input mode_select, input strobe_res, output ready);
endinterface

### rtl/core/lpfrs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lpfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 384,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lpfrs_rx.sv
// Frame receiver: unstuffs bytes, tracks board/offset, issues framebuffer writes.
// Depends on lpfrs_pkg. Also keeps the fill mark of the framebuffer.
`timescale 1ns / 1ps

module lpfrs_rx (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_en,
    input  logic [7:0]                rx_byte,
    output lpfrs_pkg::wr_req_t        wr,
    output logic [lpfrs_pkg::FILL_W-1:0] fill
);

    import lpfrs_pkg::*;

    logic                active_reg, active_next;
    logic                esc_reg, esc_next;
    logic [BOARD_W-1:0]  board_reg, board_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [7:0]          data_val;
    logic                act_tmp;
    wr_req_t             wr_c;

    // Decode one received byte
    always_comb
    begin
        active_next = active_reg;
        esc_next    = esc_reg;
        board_next  = board_reg;
        offset_next = offset_reg;
        fill_next   = fill_reg;
        data_val    = rx_byte;
        act_tmp     = active_reg;
        wr_c.en     = 1'b0;
        wr_c.addr   = {board_reg, offset_reg};
        wr_c.data   = rx_byte;
        if (byte_en)
        begin
            priority if (rx_byte == SYM_SOH)
            begin
                active_next = 1'b1;
                board_next  = '0;
                offset_next = '0;
            end
            else if (rx_byte == SYM_ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                // Resolve a pending escape; a bad code drops the frame
                if (esc_reg)
                begin
                    priority if (rx_byte == SYM_X_SOH) data_val = SYM_SOH;
                    else if (rx_byte == SYM_X_EOT)     data_val = SYM_EOT;
                    else if (rx_byte == SYM_X_ESC)     data_val = SYM_ESC;
                    else                               act_tmp  = 1'b0;
                    esc_next = 1'b0;
                end
                active_next = act_tmp;
                if (act_tmp)
                begin
                    wr_c.en     = 1'b1;
                    wr_c.data   = data_val;
                    offset_next = offset_reg + 1'b1;
                    if (offset_reg == '1)
                    begin
                        board_next = board_reg + 1'b1;
                    end
                    if ((FILL_W'(wr_c.addr) >= fill_reg))
                    begin
                        fill_next = FILL_W'(wr_c.addr) + 1'b1;
                    end
                    // Frame full after the last board
                    if ((32'(board_next) >= BOARDS) ||
                        (board_next == '0 && offset_next == '0))
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    // Hold receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            esc_reg    <= 1'b0;
            board_reg  <= '0;
            offset_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            esc_reg    <= esc_next;
            board_reg  <= board_next;
            offset_reg <= offset_next;
            fill_reg   <= fill_next;
        end
    end

    assign wr   = wr_c;
    assign fill = fill_reg;

endmodule

### rtl/core/lpfrs_scan.sv
// Row scanner: sequences bank selects, pixel bytes, row address and hold ticks.
// Depends on lpfrs_pkg. Produces the framebuffer read address for each tick.
`timescale 1ns / 1ps

module lpfrs_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    output lpfrs_pkg::scan_ctl_t ctl
);

    import lpfrs_pkg::*;

    typedef enum logic [1:0] {
        PH_BANK,
        PH_PIX,
        PH_ROW,
        PH_HOLD
    } phase_t;

    phase_t             phase_reg;
    logic [2:0]         row_reg;
    logic [1:0]         bank_reg;
    logic [BOARD_W-1:0] board_reg;
    logic               hi_reg;
    logic [2:0]         bit_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic [1:0]         bank_val;
    scan_ctl_t          ctl_c;

    // Decode the current step
    always_comb
    begin
        bank_val      = ~bank_reg;
        ctl_c.rd_addr = {board_reg, row_reg, bank_reg, hi_reg};
        ctl_c.pix     = 1'b0;
        ctl_c.bit_idx = bit_reg;
        ctl_c.data    = 1'b0;
        ctl_c.clk     = 1'b1;
        ctl_c.mode    = 1'b1;
        ctl_c.strobe  = 1'b1;
        unique case (phase_reg)
            PH_BANK:
            begin
                ctl_c.data = (bit_reg[2:1] == 2'b00) ? bank_val[bit_reg[0]] : 1'b0;
            end
            PH_PIX:
            begin
                ctl_c.pix  = 1'b1;
                ctl_c.mode = 1'b0;
            end
            PH_ROW:
            begin
                ctl_c.data = (bit_reg == row_reg);
            end
            PH_HOLD:
            begin
                ctl_c.clk    = 1'b0;
                ctl_c.mode   = 1'b0;
                ctl_c.strobe = 1'b0;
            end
            default:
            begin
                ctl_c.clk = 1'b0;
            end
        endcase
    end

    // Advance the scan one tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BANK;
            row_reg   <= '0;
            bank_reg  <= '0;
            board_reg <= '0;
            hi_reg    <= 1'b0;
            bit_reg   <= '0;
            hold_reg  <= '0;
        end
        else if (tick)
        begin
            unique case (phase_reg)
                PH_BANK:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        phase_reg <= PH_PIX;
                        board_reg <= BOARD_W'(BOARDS - 1);
                        hi_reg    <= 1'b1;
                    end
                end
                PH_PIX:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        priority if (hi_reg)
                        begin
                            hi_reg <= 1'b0;
                        end
                        else if (board_reg != '0)
                        begin
                            board_reg <= board_reg - 1'b1;
                            hi_reg    <= 1'b1;
                        end
                        else if (bank_reg == 2'd3)
                        begin
                            phase_reg <= PH_ROW;
                        end
                        else
                        begin
                            bank_reg  <= bank_reg + 1'b1;
                            phase_reg <= PH_BANK;
                        end
                    end
                end
                PH_ROW:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        phase_reg <= PH_HOLD;
                        hold_reg  <= '0;
                    end
                end
                PH_HOLD:
                begin
                    hold_reg <= hold_reg + 1'b1;
                    if (hold_reg == HOLD_W'(HOLD_TICKS - 1))
                    begin
                        phase_reg <= PH_BANK;
                        bank_reg  <= '0;
                        bit_reg   <= '0;
                        row_reg   <= row_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_BANK;
                end
            endcase
        end
    end

    assign ctl = ctl_c;

endmodule

### rtl/core/led_panel_frame_receiver_scanner_top.sv
// Top level of the LED panel frame receiver and row scanner.
// Depends on lpfrs_pkg, lpfrs_in_if, lpfrs_out_if, lpfrs_ram, lpfrs_rx, lpfrs_scan.
`timescale 1ns / 1ps

// Accepts one word per cycle while the output side keeps taking results. A
// received-byte word is unstuffed and written straight into the framebuffer
// RAM and yields no result. A scan-tick word reads one framebuffer byte and
// yields one result, through the RAM read register and then the output
// register. The framebuffer needs no clearing pass after reset: frames always
// fill from address zero upward, so a fill mark tells written bytes from
// never-written ones, which read as zero. Throughput is set by the single RAM
// port pair: one word per cycle while the output side keeps taking results.
module led_panel_frame_receiver_scanner_top (
    input  logic        clk,
    input  logic        rst_n,
    lpfrs_in_if.sink    item,
    lpfrs_out_if.source result
);

    import lpfrs_pkg::*;

    logic              accept;
    logic              byte_en;
    logic              tick;
    wr_req_t           wr;
    logic [FILL_W-1:0] fill;
    scan_ctl_t         ctl;
    logic [7:0]        rd_data;

    logic              s1_valid_reg;
    scan_ctl_t         s1_ctl_reg;
    logic              s1_hit_reg;
    logic              s1_adv;

    logic              out_valid_reg;
    logic              out_data_reg;
    logic              out_clk_reg;
    logic              out_mode_reg;
    logic              out_strobe_reg;
    logic              s1_bit;

    // Accept while the read stage can empty
    assign s1_adv     = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;
    assign byte_en    = accept && (item.operation == OP_RX_BYTE);
    assign tick       = accept && (item.operation == OP_SCAN_TICK);

    lpfrs_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (item.rx_byte),
        .wr      (wr),
        .fill    (fill)
    );

    lpfrs_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .ctl   (ctl)
    );

    lpfrs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (tick),
        .raddr (ctl.rd_addr),
        .rdata (rd_data)
    );

    // Read stage: hold the tick's control while the RAM delivers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_ctl_reg <= ctl;
            s1_hit_reg <= (FILL_W'(ctl.rd_addr) < fill);
        end
    end

    // Pick the pixel bit, MSB first
    assign s1_bit = s1_ctl_reg.pix ?
                    (s1_hit_reg & rd_data[3'd7 - s1_ctl_reg.bit_idx]) :
                    s1_ctl_reg.data;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg   <= s1_bit;
            out_clk_reg    <= s1_ctl_reg.clk;
            out_mode_reg   <= s1_ctl_reg.mode;
            out_strobe_reg <= s1_ctl_reg.strobe;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.shift_data  = out_data_reg;
    assign result.shift_clock = out_clk_reg;
    assign result.mode_select = out_mode_reg;
    assign result.strobe_res  = out_strobe_reg;

endmodule

### dv/lpfrs_scan_checker.sv
// Scoreboard for the LED panel frame receiver and scanner: watches both channels,
// predicts every scan result, and counts mismatches. Depends on lpfrs_pkg,
// lpfrs_in_if and lpfrs_out_if.
`timescale 1ns / 1ps

module lpfrs_scan_checker (
    input  logic clk,
    input  logic rst_n,
    lpfrs_in_if  item,
    lpfrs_out_if result,
    output int   errors,
    output int   pending,
    output int   words_in,
    output int   results_out,
    output int   rows_done
);
    import lpfrs_pkg::*;

    localparam int BANK_STEPS  = 8 + 16 * BOARDS;
    localparam int PIXEL_STEPS = 4 * BANK_STEPS;
    localparam int ROW_STEPS   = PIXEL_STEPS + 8 + HOLD_TICKS;

    typedef struct packed {
        logic shift_data;
        logic shift_clock;
        logic mode_select;
        logic strobe_res;
    } scan_bits_t;

    // Shadow copy of the framebuffer, receiver and scanner state
    logic [7:0]          frame_mem [STORE_SIZE];
    logic                rx_active;
    logic                esc_armed;
    logic [BOARD_W-1:0]  rx_board;
    logic [OFFSET_W-1:0] rx_offset;
    logic [2:0]          scan_row;
    logic [8:0]          scan_step;

    scan_bits_t scan_bits_q [$];

    // Unstuff one received byte and write it into the shadow framebuffer
    function automatic void absorb_rx_byte(logic [7:0] b);
        logic [7:0]  v;
        int unsigned idx;
        v = b;
        if (b == SYM_SOH)
        begin
            rx_active = 1'b1;
            rx_board  = '0;
            rx_offset = '0;
        end
        else if (b == SYM_ESC)
        begin
            esc_armed = 1'b1;
        end
        else
        begin
            // Resolve a pending escape; a bad one drops the frame
            if (esc_armed)
            begin
                unique case (b)
                    SYM_X_SOH: v = SYM_SOH;
                    SYM_X_EOT: v = SYM_EOT;
                    SYM_X_ESC: v = SYM_ESC;
                    default:   rx_active = 1'b0;
                endcase
                esc_armed = 1'b0;
            end
            if (rx_active)
            begin
                idx = rx_board * BYTES_PER_BOARD + rx_offset;
                if (idx < STORE_SIZE)
                    frame_mem[idx] = v;
                rx_offset = rx_offset + 1'b1;
                if (rx_offset == 0)
                    rx_board = rx_board + 1'b1;
                // Go idle once the last board is full
                if (rx_board >= BOARDS || (rx_board == 0 && rx_offset == 0))
                    rx_active = 1'b0;
            end
        end
    endfunction

    // Produce the panel signals for one scan tick and advance the scan
    function automatic scan_bits_t predict_scan_tick();
        scan_bits_t  r;
        int unsigned bank, t, u, brd, bit_slot, pos, sel;
        r = '0;
        if (scan_step < PIXEL_STEPS)
        begin
            bank = scan_step / BANK_STEPS;
            t    = scan_step % BANK_STEPS;
            r.shift_clock = 1'b1;
            r.strobe_res  = 1'b1;
            if (t < 8)
            begin
                // Bank select, LSB first
                sel           = 3 - bank;
                r.mode_select = 1'b1;
                r.shift_data  = sel[t];
            end
            else
            begin
                // Pixel bytes: last board first, higher byte first, MSB first
                u        = t - 8;
                brd      = BOARDS - 1 - u / 16;
                bit_slot = u % 16;
                pos      = scan_row * 8 + bank * 2 + ((bit_slot < 8) ? 1 : 0);
                r.shift_data = frame_mem[brd * BYTES_PER_BOARD + pos][7 - (bit_slot % 8)];
            end
        end
        else if (scan_step < PIXEL_STEPS + 8)
        begin
            // One-hot row address
            r.shift_clock = 1'b1;
            r.strobe_res  = 1'b1;
            r.mode_select = 1'b1;
            r.shift_data  = (int'(scan_step) - PIXEL_STEPS) == int'(scan_row);
        end
        if (scan_step == ROW_STEPS - 1)
        begin
            scan_step = '0;
            scan_row  = scan_row + 1'b1;
            rows_done++;
        end
        else
        begin
            scan_step = scan_step + 1'b1;
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string what, scan_bits_t want, scan_bits_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: scan result %0d %s: data/clk/mode/strobe expected %b%b%b%b, got %b%b%b%b",
                     $realtime, results_out, what, want.shift_data, want.shift_clock,
                     want.mode_select, want.strobe_res, got.shift_data, got.shift_clock,
                     got.mode_select, got.strobe_res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_bits_t want, got;
        int         i;
        if (!rst_n)
        begin
            for (i = 0; i < STORE_SIZE; i++)
                frame_mem[i] = '0;
            rx_active   = 1'b0;
            esc_armed   = 1'b0;
            rx_board    = '0;
            rx_offset   = '0;
            scan_row    = '0;
            scan_step   = '0;
            scan_bits_q.delete();
            errors      = 0;
            pending     = 0;
            words_in    = 0;
            results_out = 0;
            rows_done   = 0;
        end
        else
        begin
            // Compare each accepted result word with the oldest prediction
            if (result.valid && result.ready)
            begin
                got.shift_data  = result.shift_data;
                got.shift_clock = result.shift_clock;
                got.mode_select = result.mode_select;
                got.strobe_res  = result.strobe_res;
                results_out++;
                if (scan_bits_q.size() == 0)
                begin
                    flag_mismatch("with no scan tick outstanding", '0, got);
                end
                else
                begin
                    want = scan_bits_q.pop_front();
                    if (got.shift_data !== want.shift_data
                        || got.shift_clock !== want.shift_clock
                        || got.mode_select !== want.mode_select
                        || got.strobe_res !== want.strobe_res)
                        flag_mismatch("differs", want, got);
                end
            end
            // Update the shadow state with each accepted input word
            if (item.valid && item.ready)
            begin
                words_in++;
                if (item.operation == OP_SCAN_TICK)
                    scan_bits_q.push_back(predict_scan_tick());
                else
                    absorb_rx_byte(item.rx_byte);
            end
            pending = scan_bits_q.size();
        end
    end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the LED panel receiver
// and scanner. Depends on lpfrs_pkg, the channel interfaces and lpfrs_scan_checker.
`timescale 1ns / 1ps

module tb_top;
    import lpfrs_pkg::*;

    localparam int RANDOM_WORDS = 220;
    localparam int TAIL_TICKS   = 60;

    logic clk = 1'b0;
    logic rst_n;

    lpfrs_in_if  rx_ch ();
    lpfrs_out_if scan_ch ();

    int errors, pending, words_in, results_out, rows_done;
    int words_sent;
    bit src_calm, src_burst, snk_calm, long_hold_req;

    always #10 clk = ~clk;

    led_panel_frame_receiver_scanner_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (rx_ch),
        .result (scan_ch)
    );

    lpfrs_scan_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (rx_ch),
        .result      (scan_ch),
        .errors      (errors),
        .pending     (pending),
        .words_in    (words_in),
        .results_out (results_out),
        .rows_done   (rows_done)
    );

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic op, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 49) == 0)
            src_calm = !src_calm;
        gap = (src_calm || src_burst) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.operation <= op;
        rx_ch.rx_byte   <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(OP_RX_BYTE, b);
    endtask

    task automatic send_tick();
        send_word(OP_SCAN_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Escape framing symbols so the byte lands in the framebuffer as data
    task automatic send_stuffed(input logic [7:0] d);
        case (d)
            SYM_SOH:
            begin
                send_byte(SYM_ESC);
                send_byte(SYM_X_SOH);
            end
            SYM_EOT:
            begin
                send_byte(SYM_ESC);
                send_byte(SYM_X_EOT);
            end
            SYM_ESC:
            begin
                send_byte(SYM_ESC);
                send_byte(SYM_X_ESC);
            end
            default: send_byte(d);
        endcase
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return SYM_SOH;
            1:       return SYM_ESC;
            2:       return SYM_X_SOH;
            3:       return SYM_X_EOT;
            4:       return SYM_X_ESC;
            5:       return SYM_EOT;
            6:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side: random stalls, calm stretches, and one long hold on request
    initial
    begin
        int stall;
        scan_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = 400;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    snk_calm = !snk_calm;
                stall = snk_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0)
            begin
                scan_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            scan_ch.ready <= 1'b1;
            @(posedge clk);
            while (!scan_ch.valid) @(posedge clk);
        end
    end

    // Hard limit on run time
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int n, start, cycles;
        rst_n           <= 1'b0;
        rx_ch.valid     <= 1'b0;
        rx_ch.operation <= OP_RX_BYTE;
        rx_ch.rx_byte   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: cleared framebuffer, idle data, extremes, raw EOT, escapes,
        // repeated escape, SOH under a pending escape, bad escape, idle escape
        send_tick();
        send_byte(8'h55);
        send_byte(SYM_SOH);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(SYM_EOT);
        send_byte(SYM_ESC);
        send_byte(SYM_X_SOH);
        send_byte(SYM_ESC);
        send_byte(SYM_ESC);
        send_byte(SYM_X_ESC);
        send_byte(SYM_ESC);
        send_byte(SYM_X_EOT);
        send_byte(8'h80);
        send_byte(SYM_ESC);
        send_byte(SYM_SOH);
        send_byte(SYM_X_ESC);
        send_byte(SYM_ESC);
        send_byte(8'h33);
        send_byte(8'haa);
        send_byte(SYM_ESC);
        send_byte(SYM_X_SOH);
        repeat (3) send_tick();
        wait_drained();

        // Back-pressure: stall the result side while ticks arrive back to back
        long_hold_req = 1'b1;
        src_burst     = 1'b1;
        repeat (60) send_tick();
        src_burst = 1'b0;
        wait_drained();

        // Random: mostly stuffed frames with ticks mixed in, plus tick bursts and noise
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    send_byte(SYM_SOH);
                    n = $urandom_range(1, 70);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            send_tick();
                        send_stuffed(8'($urandom_range(0, 255)));
                    end
                end
                5, 6, 7: repeat ($urandom_range(1, 40)) send_tick();
                default: repeat ($urandom_range(1, 6)) send_byte(noise_byte());
            endcase
        end
        wait_drained();

        // Full frame, overflow bytes, then scan a stretch of the filled panel
        send_byte(SYM_SOH);
        repeat (STORE_SIZE) send_stuffed(8'($urandom_range(0, 255)));
        repeat (3) send_byte(8'h80 | 8'($urandom_range(0, 127)));
        repeat (TAIL_TICKS) send_tick();

        // Drain, then watch a little longer for stray results
        rx_ch.valid <= 1'b0;
        cycles = 0;
        @(negedge clk);
        while (pending != 0 && cycles < 20000)
        begin
            @(negedge clk);
            cycles++;
        end
        repeat (20) @(posedge clk);

        $display("covered %0d input words, %0d scan results checked, %0d panel rows scanned",
                 words_in, results_out, rows_done);
        $display("%0d mismatches, %0d results never arrived", errors, pending);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
